### sv/bgd_pkg.sv
`default_nettype none
package bgd_pkg;

  // Default timestamp width
  localparam int TIME_BITS_DEF = 32;

  // Field widths
  localparam int NOW_W   = 32;
  localparam int CFG_W   = 16;
  localparam int TOTAL_W = 32;
  localparam int EV_W    = 2;
  localparam int IDX_W   = 2;

  // Register reset values
  localparam logic [CFG_W-1:0] CLICK_WINDOW_RST = 16'd400;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd250;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CLICK_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;

  // Total adjustments
  localparam logic [TOTAL_W-1:0] ADJ_TRIPLE = 32'd100;
  localparam logic [TOTAL_W-1:0] ADJ_FOUR   = 32'd10;
  localparam logic [TOTAL_W-1:0] ADJ_HOLD   = 32'd5;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE       = 2'd0;
  localparam logic [EV_W-1:0] ONE_TRIPLE    = 2'd3;
  localparam logic [EV_W-1:0] ONE_DOUBLE    = 2'd2;
  localparam logic [EV_W-1:0] TWO_SHORT     = 2'd1;
  localparam logic [EV_W-1:0] TWO_LONG      = 2'd2;
  localparam logic [EV_W-1:0] THREE_REPEAT  = 2'd1;
  localparam logic [EV_W-1:0] THREE_SHORT   = 2'd2;
  localparam logic [EV_W-1:0] FOUR_DOUBLE   = 2'd1;
  localparam logic [EV_W-1:0] FOUR_SINGLE   = 2'd2;

  // Click counter values
  localparam logic [1:0] CNT_IDLE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic [3:0] prev_levels;
    logic [1:0] one_count;
    logic       four_pending;
  } bgd_ctl_t;

  typedef struct packed {
    logic [EV_W-1:0] one_clicks;
    logic [EV_W-1:0] two_release;
    logic [EV_W-1:0] three_event;
    logic [EV_W-1:0] four_event;
  } bgd_events_t;

  typedef struct packed {
    logic [CFG_W-1:0] click_window;
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] double_click;
  } bgd_cfg_t;

endpackage
`default_nettype wire

### sv/bgd_step.sv
`default_nettype none
module bgd_step #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
  input  wire logic [3:0]                   levels,
  input  wire logic [TIME_BITS-1:0]         now,
  input  wire bgd_pkg::bgd_cfg_t            cfg,
  input  wire bgd_pkg::bgd_ctl_t            ctl,
  input  wire logic [TIME_BITS-1:0]         one_start,
  input  wire logic [TIME_BITS-1:0]         two_start,
  input  wire logic [TIME_BITS-1:0]         three_start,
  input  wire logic [TIME_BITS-1:0]         four_start,
  input  wire logic [bgd_pkg::TOTAL_W-1:0]  total,
  output bgd_pkg::bgd_ctl_t                 ctl_next,
  output logic [TIME_BITS-1:0]              one_start_next,
  output logic [TIME_BITS-1:0]              two_start_next,
  output logic [TIME_BITS-1:0]              three_start_next,
  output logic [TIME_BITS-1:0]              four_start_next,
  output logic [bgd_pkg::TOTAL_W-1:0]       total_next,
  output bgd_pkg::bgd_events_t              events
);

  logic [3:0] fall, rise;
  logic [TIME_BITS-1:0] win1, longp, win4;
  logic [TIME_BITS-1:0] el1a, el1b, el2, el3, el4a, el4b;
  logic [1:0] cnt_mid, cnt_next;
  logic [bgd_pkg::EV_W-1:0] ev1_mid, ev1, ev2, ev3, ev4;
  logic [bgd_pkg::TOTAL_W-1:0] t1, t3;
  logic pend_mid, pend_next;

  assign fall = ~levels & ctl.prev_levels;
  assign rise = levels & ~ctl.prev_levels;

  assign win1  = TIME_BITS'(cfg.click_window);
  assign longp = TIME_BITS'(cfg.long_press);
  assign win4  = TIME_BITS'(cfg.double_click);

  // wrapping elapsed times
  assign el1a = now - one_start;
  assign el1b = now - one_start_next;
  assign el2  = now - two_start;
  assign el3  = now - three_start;
  assign el4a = now - four_start;
  assign el4b = now - four_start_next;

  // button one: press counting, then timeout
  always_comb begin
    one_start_next = one_start;
    cnt_mid        = ctl.one_count;
    ev1_mid        = bgd_pkg::EV_NONE;
    t1             = total;
    if (fall[0]) begin
      unique case (ctl.one_count)
        bgd_pkg::CNT_IDLE: begin
          one_start_next = now;
          cnt_mid        = bgd_pkg::CNT_ONE;
        end
        bgd_pkg::CNT_ONE: cnt_mid = bgd_pkg::CNT_TWO;
        default: begin
          if (el1a < win1) begin
            t1      = total + bgd_pkg::ADJ_TRIPLE;
            ev1_mid = bgd_pkg::ONE_TRIPLE;
          end else begin
            t1      = total + bgd_pkg::TOTAL_W'(bgd_pkg::CNT_TWO);
            ev1_mid = bgd_pkg::ONE_DOUBLE;
          end
          cnt_mid = bgd_pkg::CNT_IDLE;
        end
      endcase
    end
    ev1      = ev1_mid;
    cnt_next = cnt_mid;
    if (ev1_mid == bgd_pkg::EV_NONE &&
        (cnt_mid == bgd_pkg::CNT_ONE || cnt_mid == bgd_pkg::CNT_TWO) && el1b >= win1) begin
      t1       = total + bgd_pkg::TOTAL_W'(cnt_mid);
      ev1      = cnt_mid;
      cnt_next = bgd_pkg::CNT_IDLE;
    end
  end

  // button two
  always_comb begin
    two_start_next = two_start;
    ev2            = bgd_pkg::EV_NONE;
    if (fall[1]) begin
      two_start_next = now;
    end else if (rise[1]) begin
      ev2 = (el2 > longp) ? bgd_pkg::TWO_LONG : bgd_pkg::TWO_SHORT;
    end
  end

  // button three
  always_comb begin
    three_start_next = three_start;
    ev3              = bgd_pkg::EV_NONE;
    t3               = t1;
    priority if (fall[2]) begin
      three_start_next = now;
    end else if (!levels[2] && !ctl.prev_levels[2]) begin
      if (el3 >= longp) begin
        t3  = t1 - bgd_pkg::ADJ_HOLD;
        ev3 = bgd_pkg::THREE_REPEAT;
      end
    end else if (rise[2]) begin
      if (el3 < longp) begin
        t3  = '0;
        ev3 = bgd_pkg::THREE_SHORT;
      end
    end
  end

  // button four
  always_comb begin
    four_start_next = four_start;
    pend_mid        = ctl.four_pending;
    ev4             = bgd_pkg::EV_NONE;
    total_next      = t3;
    if (fall[3]) begin
      if (!ctl.four_pending) begin
        four_start_next = now;
        pend_mid        = 1'b1;
      end else if (el4a < win4) begin
        total_next = t3 + bgd_pkg::ADJ_FOUR;
        pend_mid   = 1'b0;
        ev4        = bgd_pkg::FOUR_DOUBLE;
      end
    end
    pend_next = pend_mid;
    if (pend_mid && el4b > win4) begin
      total_next = t3 - bgd_pkg::ADJ_FOUR;
      pend_next  = 1'b0;
      ev4        = bgd_pkg::FOUR_SINGLE;
    end
  end

  always_comb begin
    events.one_clicks     = ev1;
    events.two_release    = ev2;
    events.three_event    = ev3;
    events.four_event     = ev4;
    ctl_next.prev_levels  = levels;
    ctl_next.one_count    = cnt_next;
    ctl_next.four_pending = pend_next;
  end

endmodule
`default_nettype wire

### sv/button_gesture_detector_core.sv
`default_nettype none
// Channel   Dir  Beat contents (tdata from bit 0 up)
// s_axis    in   levels one..four [3:0], now_ms [35:4], zero pad [39:36]
// m_axis    out  one_clicks, two_release, three_event, four_event, running_total
// cfg       in   cfg_index selects register, cfg_data 16-bit value
//
// One scan per cycle: a beat is taken every clock while the result register is
// empty or being drained, and its result appears on m_axis in the next cycle.
// All gesture state is updated on the accepting edge by the single-pass logic
// in bgd_step; the result register is the only stage.
// rst (synchronous) restores released levels, zero times, counters and total,
// and the register defaults 400 / 1000 / 250 ms. cfg_ready is always high.
// A stalled m_axis holds its beat; s_axis_tready follows it.
module button_gesture_detector_core #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] button_one_level, [1] two, [2] three, [3] four, [35:4] now_ms, [39:36] zero
  input  wire logic [39:0]                  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] one_clicks, [3:2] two_release, [5:4] three_event, [7:6] four_event,
  // [39:8] running_total
  output logic [39:0]                       m_axis_tdata,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bgd_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [bgd_pkg::CFG_W-1:0]    cfg_data
);

  bgd_pkg::bgd_cfg_t    cfg;
  bgd_pkg::bgd_ctl_t    ctl, ctl_next;
  bgd_pkg::bgd_events_t events;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] one_start, two_start, three_start, four_start;
  logic [TIME_BITS-1:0] one_start_next, two_start_next, three_start_next, four_start_next;
  logic [bgd_pkg::TOTAL_W-1:0] total, total_next;
  logic [bgd_pkg::NOW_W-1:0] now_in;
  logic accept;

  assign now_in = s_axis_tdata[35:4];

  // timestamps are taken modulo 2^TIME_BITS
  generate
    if (TIME_BITS <= bgd_pkg::NOW_W) begin : g_now_trunc
      assign now = now_in[TIME_BITS-1:0];
    end else begin : g_now_ext
      assign now = {{(TIME_BITS-bgd_pkg::NOW_W){1'b0}}, now_in};
    end
  endgenerate

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // configuration registers; unlisted index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_window <= bgd_pkg::CLICK_WINDOW_RST;
      cfg.long_press   <= bgd_pkg::LONG_PRESS_RST;
      cfg.double_click <= bgd_pkg::DOUBLE_CLICK_RST;
    end else if (cfg_valid) begin
      if (cfg_index == bgd_pkg::REG_CLICK_WINDOW) cfg.click_window <= cfg_data;
      if (cfg_index == bgd_pkg::REG_LONG_PRESS)   cfg.long_press   <= cfg_data;
      if (cfg_index == bgd_pkg::REG_DOUBLE_CLICK) cfg.double_click <= cfg_data;
    end
  end

  bgd_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .levels           (s_axis_tdata[3:0]),
    .now              (now),
    .cfg              (cfg),
    .ctl              (ctl),
    .one_start        (one_start),
    .two_start        (two_start),
    .three_start      (three_start),
    .four_start       (four_start),
    .total            (total),
    .ctl_next         (ctl_next),
    .one_start_next   (one_start_next),
    .two_start_next   (two_start_next),
    .three_start_next (three_start_next),
    .four_start_next  (four_start_next),
    .total_next       (total_next),
    .events           (events)
  );

  // gesture state, advanced once per accepted scan
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.prev_levels  <= '1;
      ctl.one_count    <= bgd_pkg::CNT_IDLE;
      ctl.four_pending <= 1'b0;
      one_start        <= '0;
      two_start        <= '0;
      three_start      <= '0;
      four_start       <= '0;
      total            <= '0;
    end else if (accept) begin
      ctl         <= ctl_next;
      one_start   <= one_start_next;
      two_start   <= two_start_next;
      three_start <= three_start_next;
      four_start  <= four_start_next;
      total       <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {total_next, events.four_event, events.three_event,
                       events.two_release, events.one_clicks};
    end
  end

endmodule
`default_nettype wire
